// ===== design/assert_macros.svh =====
// Assertion macros shared by the power sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dps_pkg.sv =====
// Package: command, action and power codes for the device power sequencer.
package dps_pkg;

    localparam int unsigned ACT_W = 4;
    localparam int unsigned DLY_W = 16;
    localparam int unsigned TIME_W = 32;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_ACTION   = 3'd1,
        CMD_START    = 3'd2,
        CMD_ABORT    = 3'd3,
        CMD_WRITE    = 3'd4,
        CMD_ONLINE   = 3'd5,
        CMD_ENG_ON   = 3'd6,
        CMD_ENG_OFF  = 3'd7
    } t_cmd;

    typedef enum logic [ACT_W-1:0] {
        ACT_ON      = 4'd0,
        ACT_OFF     = 4'd1,
        ACT_REBOOT  = 4'd2,
        ACT_STANDBY = 4'd3,
        ACT_ESTOP   = 4'd4,
        ACT_INPUT   = 4'd5,
        ACT_MUTE    = 4'd6,
        ACT_UNMUTE  = 4'd7,
        ACT_QUERY   = 4'd8,
        ACT_CUSTOM  = 4'd9
    } t_action;

    typedef enum logic [1:0] {
        PWR_OFF     = 2'd0,
        PWR_STANDBY = 2'd1,
        PWR_ON      = 2'd2,
        PWR_FAULT   = 2'd3
    } t_power;

endpackage

// ===== design/dps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dps_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/device_power_sequencer_unit.sv =====
// Device power sequencer: per-device power and online state plus a timed step engine.
//
// One command is taken per clock: a transfer happens when start is high and busy is
// low, and busy is high only during reset and in the cycle right after it. Every
// command gives exactly one result, shown on the o_ ports for one cycle with o_valid
// in the cycle after its transfer; the receiver cannot stall, so it must capture each
// result on the strobe. The step store is a RAM with registered read; the step that
// the run points at is read early from the next-state pointer, and a step written
// into that slot is forwarded, so back-to-back commands and ticks run at full rate.
module device_power_sequencer_unit
    import dps_pkg::*;
#(
    parameter int unsigned NUM_DEVICES = 16,
    parameter int unsigned MAX_STEPS   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          i_command,
    input  logic [TIME_W-1:0]                   i_time_ms,
    input  logic [$clog2(NUM_DEVICES)-1:0]      i_device,
    input  logic [ACT_W-1:0]                    i_action,
    input  logic [$clog2(MAX_STEPS)-1:0]        i_step_addr,
    input  logic [DLY_W-1:0]                    i_step_delay_ms,
    input  logic [$clog2(MAX_STEPS+1)-1:0]      i_run_length,
    input  logic                                i_online_flag,
    output logic                                o_valid,
    output logic                                o_accepted,
    output logic [1:0]                          o_target_power,
    output logic                                o_step_fired,
    output logic [$clog2(NUM_DEVICES)-1:0]      o_fired_device,
    output logic [ACT_W-1:0]                    o_fired_action,
    output logic                                o_fired_ok,
    output logic                                o_run_active,
    output logic [$clog2(MAX_STEPS+1)-1:0]      o_run_position,
    output logic                                o_run_finished
);

`include "assert_macros.svh"

    localparam int unsigned DEV_W = $clog2(NUM_DEVICES);
    localparam int unsigned AW    = $clog2(MAX_STEPS);
    localparam int unsigned IW    = $clog2(MAX_STEPS + 1);
    localparam int unsigned SW    = IW + 1;
    localparam int unsigned ENT_W = DEV_W + ACT_W + DLY_W;

    localparam logic [DEV_W:0] NDEV_C = (DEV_W + 1)'(NUM_DEVICES);
    localparam logic [AW:0]    AMAX_C = (AW + 1)'(MAX_STEPS);
    localparam logic [IW-1:0]  LMAX_C = IW'(MAX_STEPS);
    localparam logic [SW-1:0]  SMAX_C = SW'(MAX_STEPS);

    // State
    t_power              r_power  [NUM_DEVICES];
    logic                r_online [NUM_DEVICES];
    logic [TIME_W-1:0]   r_clock;
    logic                r_engine;
    logic                r_run_on;
    logic [AW-1:0]       r_base;
    logic [IW-1:0]       r_count;
    logic [IW-1:0]       r_index;
    logic [DLY_W-1:0]    r_wait;
    logic                r_busy;
    logic                r_byp;
    logic [ENT_W-1:0]    r_byp_data;

    // Result registers
    logic                r_valid;
    logic                r_acc;
    t_power              r_tpow;
    logic                r_fired;
    logic [DEV_W-1:0]    r_fdev;
    logic [ACT_W-1:0]    r_fact;
    logic                r_fok;
    logic                r_fin;

    // Next values
    t_power              n_power  [NUM_DEVICES];
    logic                n_online [NUM_DEVICES];
    logic [TIME_W-1:0]   n_clock;
    logic                n_engine;
    logic                n_run_on;
    logic [AW-1:0]       n_base;
    logic [IW-1:0]       n_count;
    logic [IW-1:0]       n_index;
    logic [DLY_W-1:0]    n_wait;
    logic                n_byp;
    logic                n_acc;
    t_power              n_tpow;
    logic                n_fired;
    logic [DEV_W-1:0]    n_fdev;
    logic [ACT_W-1:0]    n_fact;
    logic                n_fok;
    logic                n_fin;

    logic                accept;
    logic                wr_en;
    logic [ENT_W-1:0]    wr_data;
    logic [ENT_W-1:0]    ram_q;
    logic [ENT_W-1:0]    entry;
    logic [DEV_W-1:0]    ent_dev;
    logic [ACT_W-1:0]    ent_act;
    logic [DLY_W-1:0]    ent_dly;
    logic [SW-1:0]       ptr_sum;
    logic [AW-1:0]       rd_addr;
    logic [TIME_W-1:0]   delta;
    logic                time_later;
    logic                do_act;
    logic [DEV_W-1:0]    a_dev;
    t_action             a_act;
    logic                a_in_range;
    logic                a_ok;

    assign accept     = start && !r_busy;
    assign wr_data    = {i_step_delay_ms, i_action, i_device};
    assign delta      = i_time_ms - r_clock;
    assign time_later = i_time_ms > r_clock;

    // Pick the prefetched step, or the step written into that slot last cycle
    assign entry   = r_byp ? r_byp_data : ram_q;
    assign ent_dev = entry[DEV_W-1:0];
    assign ent_act = entry[DEV_W +: ACT_W];
    assign ent_dly = entry[DEV_W+ACT_W +: DLY_W];

    // Command decode and run engine
    always_comb begin
        n_power  = r_power;
        n_online = r_online;
        n_clock  = r_clock;
        n_engine = r_engine;
        n_run_on = r_run_on;
        n_base   = r_base;
        n_count  = r_count;
        n_index  = r_index;
        n_wait   = r_wait;
        n_acc    = 1'b0;
        n_tpow   = PWR_OFF;
        n_fired  = 1'b0;
        n_fdev   = '0;
        n_fact   = '0;
        n_fok    = 1'b0;
        n_fin    = 1'b0;
        wr_en    = 1'b0;
        do_act   = 1'b0;
        a_dev    = i_device;
        a_act    = t_action'(i_action);

        if (accept) begin
            case (t_cmd'(i_command))
                CMD_TICK: begin
                    if (r_engine) begin
                        n_acc   = 1'b1;
                        n_clock = i_time_ms;
                        if (time_later && r_run_on) begin
                            if (r_index >= r_count) begin
                                n_run_on = 1'b0;
                                n_fin    = 1'b1;
                            end else if (r_wait == '0) begin
                                n_fired = 1'b1;
                                n_fdev  = ent_dev;
                                n_fact  = ent_act;
                                a_dev   = ent_dev;
                                a_act   = t_action'(ent_act);
                                do_act  = 1'b1;
                                n_wait  = ent_dly;
                                if (ent_dly == '0) begin
                                    n_index = r_index + IW'(1);
                                end
                            end else if (delta >= TIME_W'(r_wait)) begin
                                n_wait  = '0;
                                n_index = r_index + IW'(1);
                            end else begin
                                n_wait = r_wait - delta[DLY_W-1:0];
                            end
                        end
                    end
                end
                CMD_ACTION: begin
                    do_act = 1'b1;
                end
                CMD_START: begin
                    if (i_run_length != '0 && i_run_length <= LMAX_C
                            && {1'b0, i_step_addr} < AMAX_C) begin
                        n_acc    = 1'b1;
                        n_run_on = 1'b1;
                        n_base   = i_step_addr;
                        n_count  = i_run_length;
                        n_index  = '0;
                        n_wait   = '0;
                    end
                end
                CMD_ABORT: begin
                    n_acc    = 1'b1;
                    n_run_on = 1'b0;
                end
                CMD_WRITE: begin
                    if ({1'b0, i_step_addr} < AMAX_C) begin
                        n_acc = 1'b1;
                        wr_en = 1'b1;
                    end
                end
                CMD_ONLINE: begin
                    if ({1'b0, i_device} < NDEV_C) begin
                        n_acc              = 1'b1;
                        n_online[i_device] = i_online_flag;
                        n_tpow             = r_power[i_device];
                    end
                end
                CMD_ENG_ON: begin
                    n_acc    = 1'b1;
                    n_engine = 1'b1;
                end
                default: begin
                    n_acc    = 1'b1;
                    n_engine = 1'b0;
                    n_run_on = 1'b0;
                end
            endcase
        end

        // Apply one device action; offline devices take only power-on and query
        a_in_range = {1'b0, a_dev} < NDEV_C;
        a_ok       = a_in_range && (r_online[a_dev] || (a_act inside {ACT_ON, ACT_QUERY}));
        if (do_act && a_ok) begin
            case (a_act)
                ACT_ON, ACT_REBOOT: n_power[a_dev] = PWR_ON;
                ACT_OFF:            n_power[a_dev] = PWR_OFF;
                ACT_STANDBY:        n_power[a_dev] = PWR_STANDBY;
                ACT_ESTOP: begin
                    for (int k = 0; k < NUM_DEVICES; k++) begin
                        n_power[k] = PWR_OFF;
                    end
                    n_run_on = 1'b0;
                end
                default: ;
            endcase
        end
        if (do_act) begin
            if (a_in_range) begin
                n_tpow = n_power[a_dev];
            end
            if (n_fired) begin
                n_fok = a_ok;
            end else begin
                n_acc = a_ok;
            end
        end
    end

    // Point the step RAM at the slot the run will use next cycle
    always_comb begin
        ptr_sum = SW'(n_base) + SW'(n_index);
        if (ptr_sum >= SMAX_C) begin
            ptr_sum = ptr_sum - SMAX_C;
        end
        rd_addr = ptr_sum[AW-1:0];
        n_byp   = wr_en && (i_step_addr == rd_addr);
    end

    dps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_STEPS)
    ) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_step_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_DEVICES; k++) begin
                r_power[k]  <= PWR_OFF;
                r_online[k] <= 1'b1;
            end
            r_clock  <= '0;
            r_engine <= 1'b0;
            r_run_on <= 1'b0;
            r_base   <= '0;
            r_count  <= '0;
            r_index  <= '0;
            r_wait   <= '0;
            r_busy   <= 1'b1;
            r_byp    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_power  <= n_power;
            r_online <= n_online;
            r_clock  <= n_clock;
            r_engine <= n_engine;
            r_run_on <= n_run_on;
            r_base   <= n_base;
            r_count  <= n_count;
            r_index  <= n_index;
            r_wait   <= n_wait;
            r_busy   <= 1'b0;
            r_byp    <= n_byp;
            r_valid  <= accept;
        end
    end

    // Capture result payload and forwarded step data
    always_ff @(posedge i_clk) begin
        r_byp_data <= wr_data;
        r_acc      <= n_acc;
        r_tpow     <= n_tpow;
        r_fired    <= n_fired;
        r_fdev     <= n_fdev;
        r_fact     <= n_fact;
        r_fok      <= n_fok;
        r_fin      <= n_fin;
    end

    assign busy           = r_busy;
    assign o_valid        = r_valid;
    assign o_accepted     = r_acc;
    assign o_target_power = r_tpow;
    assign o_step_fired   = r_fired;
    assign o_fired_device = r_fdev;
    assign o_fired_action = r_fact;
    assign o_fired_ok     = r_fok;
    assign o_run_active   = r_run_on;
    assign o_run_position = r_index;
    assign o_run_finished = r_fin;

    // Checks on the run engine and the result strobe
    `ASSERT_NEXT(a_valid_follows_transfer, i_clk, i_rst_n, 1'b1, o_valid == $past(start && !busy), "result strobe does not follow transfer")
    `ASSERT_NOW(a_index_in_run, i_clk, i_rst_n, 1'b1, r_index <= r_count, "run index beyond run length")
    `ASSERT_NOW(a_wait_inside_run, i_clk, i_rst_n, r_wait != '0, r_index < r_count, "pending wait with no step left")
    `ASSERT_NOW(a_finish_ends_run, i_clk, i_rst_n, o_valid && o_run_finished, !o_run_active && !o_step_fired, "finished run still active")
    `ASSERT_NOW(a_fire_on_accepted_tick, i_clk, i_rst_n, o_valid && o_step_fired, o_accepted, "step fired on refused command")

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the device power sequencer: directed table, random commands, self-checking.
module tb_top
    import dps_pkg::*;
();

    localparam int DEV_N       = 16;
    localparam int STEP_N      = 64;
    localparam int RAND_ITEMS  = 1750;
    localparam int STALL_LIMIT = 500;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] time_ms;
        logic [3:0]  dev;
        logic [3:0]  act;
        logic [5:0]  addr;
        logic [15:0] dly;
        logic [6:0]  len;
        logic        flag;
    } seq_cmd_t;

    typedef struct packed {
        logic       acc;
        logic [1:0] tpow;
        logic       fired;
        logic [3:0] fdev;
        logic [3:0] fact;
        logic       fok;
        logic       run_on;
        logic [6:0] pos;
        logic       fin;
    } seq_status_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_command = CMD_TICK;
    logic [31:0] i_time_ms = '0;
    logic [3:0]  i_device = '0;
    logic [3:0]  i_action = '0;
    logic [5:0]  i_step_addr = '0;
    logic [15:0] i_step_delay_ms = '0;
    logic [6:0]  i_run_length = '0;
    logic        i_online_flag = 1'b0;
    logic        o_valid;
    logic        o_accepted;
    logic [1:0]  o_target_power;
    logic        o_step_fired;
    logic [3:0]  o_fired_device;
    logic [3:0]  o_fired_action;
    logic        o_fired_ok;
    logic        o_run_active;
    logic [6:0]  o_run_position;
    logic        o_run_finished;

    // Command currently on the ports, plus a typed expectation for fixed table rows
    seq_cmd_t    cmd_now = '0;
    logic        cmd_fixed = 1'b0;
    seq_status_t cmd_fixed_res = '0;

    // Predicted sequencer state
    logic [1:0]  dev_power [DEV_N];
    logic        dev_online [DEV_N];
    logic [23:0] step_mem [STEP_N];
    logic [31:0] clk_now;
    logic        eng_running;
    logic        seq_run_on;
    logic [5:0]  run_base;
    logic [6:0]  run_cnt;
    logic [6:0]  run_idx;
    logic [15:0] wait_left;

    // Generator shadow: slots written so far, engine state, running time base
    logic [STEP_N-1:0] step_written = '0;
    logic              gen_engine = 1'b0;
    logic [31:0]       gen_time = 32'd100;
    logic              no_idle = 1'b0;

    seq_status_t status_q [$];
    seq_cmd_t    plan_cmd [$];
    logic        plan_fixed [$];
    seq_status_t plan_res [$];

    int err_count = 0;
    int n_items = 0;
    int n_fired = 0;
    int n_finished = 0;
    int n_refused = 0;
    int idle_cycles = 0;

    device_power_sequencer_unit #(
        .NUM_DEVICES (DEV_N),
        .MAX_STEPS   (STEP_N)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_time_ms       (i_time_ms),
        .i_device        (i_device),
        .i_action        (i_action),
        .i_step_addr     (i_step_addr),
        .i_step_delay_ms (i_step_delay_ms),
        .i_run_length    (i_run_length),
        .i_online_flag   (i_online_flag),
        .o_valid         (o_valid),
        .o_accepted      (o_accepted),
        .o_target_power  (o_target_power),
        .o_step_fired    (o_step_fired),
        .o_fired_device  (o_fired_device),
        .o_fired_action  (o_fired_action),
        .o_fired_ok      (o_fired_ok),
        .o_run_active    (o_run_active),
        .o_run_position  (o_run_position),
        .o_run_finished  (o_run_finished)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one action to a device; return whether the device took it
    function automatic logic dev_apply(logic [3:0] dev, logic [3:0] act);
        if (int'(dev) >= DEV_N) return 1'b0;
        if (!dev_online[dev] && act != ACT_ON && act != ACT_QUERY) return 1'b0;
        case (act)
            ACT_ON, ACT_REBOOT: dev_power[dev] = PWR_ON;
            ACT_OFF:            dev_power[dev] = PWR_OFF;
            ACT_STANDBY:        dev_power[dev] = PWR_STANDBY;
            ACT_ESTOP: begin
                for (int k = 0; k < DEV_N; k++) dev_power[k] = PWR_OFF;
                seq_run_on = 1'b0;
            end
            default: ;
        endcase
        return 1'b1;
    endfunction

    // Advance the predicted sequencer by one command and return its status
    function automatic seq_status_t sequencer_status(seq_cmd_t c);
        seq_status_t r;
        logic [31:0] older;
        logic [31:0] span;
        logic [23:0] entry;
        r = '0;
        case (c.cmd)
            CMD_TICK: begin
                if (eng_running) begin
                    r.acc = 1'b1;
                    older = clk_now;
                    clk_now = c.time_ms;
                    span = c.time_ms - older;
                    if (c.time_ms > older && seq_run_on) begin
                        if (run_idx >= run_cnt) begin
                            seq_run_on = 1'b0;
                            r.fin = 1'b1;
                        end else if (wait_left == 0) begin
                            entry = step_mem[run_base + run_idx[5:0]];
                            r.fired = 1'b1;
                            r.fdev = entry[3:0];
                            r.fact = entry[7:4];
                            r.fok = dev_apply(entry[3:0], entry[7:4]);
                            if (int'(entry[3:0]) < DEV_N) r.tpow = dev_power[entry[3:0]];
                            wait_left = entry[23:8];
                            if (wait_left == 0) run_idx = run_idx + 7'd1;
                        end else if (span >= {16'd0, wait_left}) begin
                            wait_left = '0;
                            run_idx = run_idx + 7'd1;
                        end else begin
                            wait_left = wait_left - span[15:0];
                        end
                    end
                end
            end
            CMD_ACTION: begin
                r.acc = dev_apply(c.dev, c.act);
                if (int'(c.dev) < DEV_N) r.tpow = dev_power[c.dev];
            end
            CMD_START: begin
                if (c.len != 0 && int'(c.len) <= STEP_N && int'(c.addr) < STEP_N) begin
                    r.acc = 1'b1;
                    seq_run_on = 1'b1;
                    run_base = c.addr;
                    run_cnt = c.len;
                    run_idx = '0;
                    wait_left = '0;
                end
            end
            CMD_ABORT: begin
                r.acc = 1'b1;
                seq_run_on = 1'b0;
            end
            CMD_WRITE: begin
                if (int'(c.addr) < STEP_N) begin
                    r.acc = 1'b1;
                    step_mem[c.addr] = {c.dly, c.act, c.dev};
                end
            end
            CMD_ONLINE: begin
                if (int'(c.dev) < DEV_N) begin
                    r.acc = 1'b1;
                    dev_online[c.dev] = c.flag;
                    r.tpow = dev_power[c.dev];
                end
            end
            CMD_ENG_ON: begin
                r.acc = 1'b1;
                eng_running = 1'b1;
            end
            default: begin
                r.acc = 1'b1;
                eng_running = 1'b0;
                seq_run_on = 1'b0;
            end
        endcase
        r.run_on = seq_run_on;
        r.pos = run_idx;
        return r;
    endfunction

    function automatic seq_cmd_t mk_cmd(t_cmd cmd, logic [31:0] t, logic [3:0] dev,
                                        logic [3:0] act, logic [5:0] addr, logic [15:0] dly,
                                        logic [6:0] len, logic flag);
        seq_cmd_t c;
        c.cmd = cmd;
        c.time_ms = t;
        c.dev = dev;
        c.act = act;
        c.addr = addr;
        c.dly = dly;
        c.len = len;
        c.flag = flag;
        return c;
    endfunction

    // Queue a table row; a fixed row carries its expected status typed in
    task automatic plan_row(seq_cmd_t c, logic fixed, logic acc, logic [1:0] tpow,
                            logic run_on, logic [6:0] pos);
        seq_status_t r;
        r = '0;
        r.acc = acc;
        r.tpow = tpow;
        r.run_on = run_on;
        r.pos = pos;
        plan_cmd.insert(plan_cmd.size(), c);
        plan_fixed.insert(plan_fixed.size(), fixed);
        plan_res.insert(plan_res.size(), r);
    endtask

    // Mostly short gaps, a few long ones, none while in a burst stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Estop stays rare so runs get a chance to finish
    function automatic logic [3:0] pick_action();
        logic [3:0] a;
        a = 4'($urandom_range(0, 15));
        if (a == ACT_ESTOP && $urandom_range(0, 3) != 0) a = 4'($urandom_range(0, 3));
        return a;
    endfunction

    function automatic logic [31:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return gen_time + $urandom_range(0, 8);
        if (r < 93) return gen_time + $urandom_range(9, 3000);
        if (r < 97) return gen_time - $urandom_range(0, 50);
        return $urandom();
    endfunction

    // Random command: runs only cover written slots, unused fields carry noise
    function automatic seq_cmd_t gen_random_cmd();
        seq_cmd_t c;
        int pick;
        int span;
        int slot;
        int r;
        c = mk_cmd(CMD_TICK, $urandom(), 4'($urandom()), pick_action(), 6'($urandom()),
                   16'($urandom()), 7'($urandom()), 1'($urandom()));
        pick = $urandom_range(0, 99);
        if (!gen_engine && pick < 60) c.cmd = CMD_ENG_ON;
        else if (pick < 45) c.cmd = CMD_TICK;
        else if (pick < 58) c.cmd = CMD_ACTION;
        else if (pick < 68) c.cmd = CMD_START;
        else if (pick < 82) c.cmd = CMD_WRITE;
        else if (pick < 89) c.cmd = CMD_ONLINE;
        else if (pick < 92) c.cmd = CMD_ABORT;
        else if (pick < 97) c.cmd = CMD_ENG_ON;
        else c.cmd = CMD_ENG_OFF;

        if (c.cmd == CMD_START) begin
            if ($urandom_range(0, 99) < 12) begin
                c.len = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
            end else begin
                span = 0;
                while (span < STEP_N && step_written[6'(c.addr + span)]) span++;
                if (span == 0) begin
                    c.cmd = CMD_WRITE;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 70) c.len = 7'($urandom_range(1, (span < 6) ? span : 6));
                    else if (r < 95) c.len = 7'($urandom_range(1, span));
                    else c.len = 7'(span);
                end
            end
        end

        case (c.cmd)
            CMD_TICK: begin
                c.time_ms = pick_time();
                gen_time = c.time_ms;
            end
            CMD_WRITE: begin
                if ($countones(step_written) < STEP_N && $urandom_range(0, 1) == 1) begin
                    slot = $urandom_range(0, STEP_N - 1);
                    while (step_written[slot]) slot = (slot + 1) % STEP_N;
                    c.addr = 6'(slot);
                end
                r = $urandom_range(0, 99);
                if (r < 60) c.dly = 16'($urandom_range(0, 4));
                else if (r < 90) c.dly = 16'($urandom_range(5, 40));
                else if (r < 98) c.dly = 16'($urandom_range(41, 2000));
            end
            CMD_ONLINE: c.flag = ($urandom_range(0, 99) < 65);
            default: ;
        endcase
        return c;
    endfunction

    // Drive one command after a random gap and hold it until the transfer
    task automatic issue_command(seq_cmd_t c, logic fixed, seq_status_t fixed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= c.cmd;
        i_time_ms <= c.time_ms;
        i_device <= c.dev;
        i_action <= c.act;
        i_step_addr <= c.addr;
        i_step_delay_ms <= c.dly;
        i_run_length <= c.len;
        i_online_flag <= c.flag;
        cmd_now <= c;
        cmd_fixed <= fixed;
        cmd_fixed_res <= fixed_res;
        if (c.cmd == CMD_WRITE) step_written[c.addr] = 1'b1;
        if (c.cmd == CMD_ENG_ON) gen_engine = 1'b1;
        if (c.cmd == CMD_ENG_OFF) gen_engine = 1'b0;
        do @(posedge i_clk); while (busy);
    endtask

    // Report one field mismatch and count it
    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            if (err_count < 40)
                $display("ERROR result %0d field %s: got %0h, want %0h",
                         n_items - status_q.size(), name, got, want);
            err_count++;
        end
    endtask

    // Check each result against the oldest expectation; predict each transfer
    always @(posedge i_clk) begin
        seq_status_t want;
        seq_status_t pred;
        if (i_rst_n && o_valid) begin
            if (status_q.size() == 0) begin
                $display("ERROR result with no command outstanding");
                err_count++;
            end else begin
                want = status_q.pop_front();
                check_field("accepted", 32'(o_accepted), 32'(want.acc));
                check_field("target_power", 32'(o_target_power), 32'(want.tpow));
                check_field("step_fired", 32'(o_step_fired), 32'(want.fired));
                check_field("fired_device", 32'(o_fired_device), 32'(want.fdev));
                check_field("fired_action", 32'(o_fired_action), 32'(want.fact));
                check_field("fired_ok", 32'(o_fired_ok), 32'(want.fok));
                check_field("run_active", 32'(o_run_active), 32'(want.run_on));
                check_field("run_position", 32'(o_run_position), 32'(want.pos));
                check_field("run_finished", 32'(o_run_finished), 32'(want.fin));
            end
        end
        if (i_rst_n && start && !busy) begin
            pred = sequencer_status(cmd_now);
            n_items++;
            if (pred.fired) n_fired++;
            if (pred.fin) n_finished++;
            if (!pred.acc) n_refused++;
            status_q.insert(status_q.size(), cmd_fixed ? cmd_fixed_res : pred);
        end
    end

    // Stop the run when nothing moves for too long
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_valid) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("ERROR watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        for (int k = 0; k < DEV_N; k++) begin
            dev_power[k] = PWR_OFF;
            dev_online[k] = 1'b1;
        end
        for (int k = 0; k < STEP_N; k++) step_mem[k] = '0;
        clk_now = '0;
        eng_running = 1'b0;
        seq_run_on = 1'b0;
        run_base = '0;
        run_cnt = '0;
        run_idx = '0;
        wait_left = '0;

        // Reset state, engine off, step writes and bad runs
        plan_row(mk_cmd(CMD_ACTION, 0, 0, ACT_QUERY, 0, 0, 0, 0), 1, 1, PWR_OFF, 0, 0);
        plan_row(mk_cmd(CMD_TICK, 100, 0, 0, 0, 0, 0, 0), 1, 0, PWR_OFF, 0, 0);
        plan_row(mk_cmd(CMD_ENG_ON, 0, 0, 0, 0, 0, 0, 0), 1, 1, PWR_OFF, 0, 0);
        plan_row(mk_cmd(CMD_WRITE, 0, 15, ACT_ON, 0, 0, 0, 0), 1, 1, PWR_OFF, 0, 0);
        plan_row(mk_cmd(CMD_WRITE, 0, 1, ACT_REBOOT, 63, 16'hFFFF, 0, 0), 1, 1, PWR_OFF, 0, 0);
        plan_row(mk_cmd(CMD_WRITE, 0, 2, ACT_STANDBY, 1, 3, 0, 0), 1, 1, PWR_OFF, 0, 0);
        // Run wraps from the last slot to the first
        plan_row(mk_cmd(CMD_START, 0, 0, 0, 63, 0, 3, 0), 1, 1, PWR_OFF, 1, 0);
        plan_row(mk_cmd(CMD_START, 0, 0, 0, 5, 0, 0, 0), 1, 0, PWR_OFF, 1, 0);
        plan_row(mk_cmd(CMD_START, 0, 0, 0, 0, 0, 127, 0), 1, 0, PWR_OFF, 1, 0);
        // Fire, long delta, clock going back, zero delay, countdown, finish
        plan_row(mk_cmd(CMD_TICK, 100, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_TICK, 1, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_TICK, 2, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_TICK, 3, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_TICK, 10, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_TICK, 11, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        // Offline device: only power-on and query get through
        plan_row(mk_cmd(CMD_ONLINE, 0, 5, 0, 0, 0, 0, 0), 1, 1, PWR_OFF, 0, 3);
        plan_row(mk_cmd(CMD_ACTION, 0, 5, ACT_OFF, 0, 0, 0, 0), 1, 0, PWR_OFF, 0, 3);
        plan_row(mk_cmd(CMD_ACTION, 0, 5, ACT_ON, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_ACTION, 0, 5, 4'd15, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_ONLINE, 0, 5, 0, 0, 0, 0, 1), 0, 0, 0, 0, 0);
        // Emergency stop drops the run, then abort and engine stop
        plan_row(mk_cmd(CMD_START, 0, 0, 0, 0, 0, 2, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_ACTION, 0, 3, ACT_ESTOP, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_ABORT, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        plan_row(mk_cmd(CMD_ENG_OFF, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_cmd[i]) issue_command(plan_cmd[i], plan_fixed[i], plan_res[i]);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
            issue_command(gen_random_cmd(), 1'b0, '0);
        end
        start <= 1'b0;

        // Drain outstanding results, then leave time for stray strobes
        @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (status_q.size() != 0) begin
            $display("ERROR %0d results never arrived", status_q.size());
            err_count++;
        end

        $display("Covered %0d commands: %0d steps fired, %0d runs finished, %0d refused",
                 n_items, n_fired, n_finished, n_refused);
        $display("Step slots written: %0d of %0d; mismatches: %0d",
                 $countones(step_written), STEP_N, err_count);
        if (err_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
